// ----- design/pid_windowed_integral_defines.svh -----
// Assertion macros shared by the controller RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PID_WINDOWED_INTEGRAL_DEFINES_SVH
`define PID_WINDOWED_INTEGRAL_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PWI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pwi assertion failed");

// Check that cons holds in the cycle after ante.
`define PWI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pwi assertion failed");

`endif

// ----- design/pwi_pkg.sv -----
// Widths, register indexes and constants of the windowed-integral PID controller.
// No dependencies; used by the channel interfaces and the top level.
package pwi_pkg;

	localparam int WINDOW_LEN = 10;
	localparam int WIN_IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

	localparam int ERR_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int LIM_W   = 32;
	localparam int DRIVE_W = 32;
	localparam int SUM_W   = ERR_W + $clog2(WINDOW_LEN);
	localparam int DIFF_W  = ERR_W + 1;
	localparam int PPROD_W = GAIN_W + ERR_W;
	localparam int IPROD_W = GAIN_W + SUM_W;
	localparam int DPROD_W = GAIN_W + DIFF_W;
	localparam int TOT_W   = IPROD_W + 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_P_GAIN           = 3'd0,
		REG_I_GAIN           = 3'd1,
		REG_D_GAIN           = 3'd2,
		REG_INTEGRAL_LIMIT   = 3'd3,
		REG_DERIVATIVE_LIMIT = 3'd4,
		REG_OUTPUT_LIMIT     = 3'd5
	} pwi_reg_t;

	localparam logic signed [LIM_W-1:0]   LIM_RESET = {1'b0, {(LIM_W-1){1'b1}}};
	localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

endpackage

// ----- design/pwi_if.sv -----
// Valid/ready channel interfaces: error samples in, drive values out, register writes.
// Depends on pwi_pkg for field widths.
interface pwi_err_if import pwi_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [ERR_W-1:0] error_sample;

	modport source (output valid, output error_sample, input ready);
	modport sink (input valid, input error_sample, output ready);
endinterface

interface pwi_drive_if import pwi_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive_value;

	modport source (output valid, output drive_value, input ready);
	modport sink (input valid, input drive_value, output ready);
endinterface

interface pwi_cfg_if import pwi_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/pid_windowed_integral.sv -----
// PID controller with a sliding-window integral: one signed Q8.8 error sample in,
// one signed Q16.16 drive value out per transfer. It takes a sample every cycle unless the
// pipeline is full and the drive side stalls. The window update, the three gain multiplies,
// then clamping and summing are each registered in turn; a stall backs up stage by stage so
// empty stages still fill while a result waits. The running window sum feeds back on itself.
// Configuration writes must be made while idle; the block itself does not enforce this.
// Depends on pwi_pkg, the channel interfaces in pwi_if.sv and the assertion macros.
`include "pid_windowed_integral_defines.svh"

module pid_windowed_integral import pwi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	pwi_cfg_if.sink            cfg,
	pwi_err_if.sink            sample,
	pwi_drive_if.source        drive
);

	logic signed [GAIN_W-1:0] p_gain_q, i_gain_q, d_gain_q;
	logic signed [LIM_W-1:0]  ilim_q, dlim_q, olim_q;

	logic signed [ERR_W-1:0]  window_q [WINDOW_LEN];
	logic [WIN_IDX_W-1:0]     wr_pos_q;
	logic signed [SUM_W-1:0]  window_sum_q;
	logic signed [ERR_W-1:0]  prev_err_q;

	logic                     v_s1, v_s2, out_v_q;
	logic signed [ERR_W-1:0]  err_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [SUM_W-1:0]  sum_s1;
	logic signed [PPROD_W-1:0] pprod_s2;
	logic signed [IPROD_W-1:0] iprod_s2;
	logic signed [DPROD_W-1:0] dprod_s2;
	logic signed [DRIVE_W-1:0] drive_q;

	logic en_out, en_s2, en_s1, accept;
	logic signed [SUM_W-1:0]  sum_nxt;
	logic signed [DIFF_W-1:0] diff_nxt;
	logic signed [TOT_W-1:0]  iext, dext, pext, ilim_ext, dlim_ext, olim_ext;
	logic signed [TOT_W-1:0]  iterm, dterm, total, total_hi, total_lim;

	assign en_out       = !out_v_q || drive.ready;
	assign en_s2        = !v_s2 || en_out;
	assign en_s1        = !v_s1 || en_s2;
	assign sample.ready = en_s1;
	assign accept       = sample.valid && en_s1;
	assign cfg.ready    = 1'b1;

	assign drive.valid       = out_v_q;
	assign drive.drive_value = drive_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q <= '0;
			i_gain_q <= '0;
			d_gain_q <= '0;
			ilim_q   <= LIM_RESET;
			dlim_q   <= LIM_RESET;
			olim_q   <= LIM_RESET;
		end else if (cfg.valid) begin
			unique case (pwi_reg_t'(cfg.index))
				REG_P_GAIN:           p_gain_q <= cfg.data[GAIN_W-1:0];
				REG_I_GAIN:           i_gain_q <= cfg.data[GAIN_W-1:0];
				REG_D_GAIN:           d_gain_q <= cfg.data[GAIN_W-1:0];
				REG_INTEGRAL_LIMIT:   ilim_q   <= cfg.data[LIM_W-1:0];
				REG_DERIVATIVE_LIMIT: dlim_q   <= cfg.data[LIM_W-1:0];
				REG_OUTPUT_LIMIT:     olim_q   <= cfg.data[LIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign sum_nxt  = window_sum_q - SUM_W'(window_q[wr_pos_q]) + SUM_W'(sample.error_sample);
	assign diff_nxt = DIFF_W'(sample.error_sample) - DIFF_W'(prev_err_q);

	// window state and first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WINDOW_LEN; k++) begin
				window_q[k] <= '0;
			end
			wr_pos_q     <= '0;
			window_sum_q <= '0;
			prev_err_q   <= '0;
			v_s1         <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= sample.valid;
			end
			if (accept) begin
				window_q[wr_pos_q] <= sample.error_sample;
				window_sum_q       <= sum_nxt;
				prev_err_q         <= sample.error_sample;
				if (wr_pos_q == WIN_IDX_W'(WINDOW_LEN - 1)) begin
					wr_pos_q <= '0;
				end else begin
					wr_pos_q <= wr_pos_q + WIN_IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1  <= sample.error_sample;
			diff_s1 <= diff_nxt;
			sum_s1  <= sum_nxt;
		end
	end

	// gain multiplies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			pprod_s2 <= PPROD_W'(p_gain_q) * PPROD_W'(err_s1);
			iprod_s2 <= IPROD_W'(i_gain_q) * IPROD_W'(sum_s1);
			dprod_s2 <= DPROD_W'(d_gain_q) * DPROD_W'(diff_s1);
		end
	end

	// clamp and sum
	always_comb begin
		pext      = TOT_W'(pprod_s2);
		iext      = TOT_W'(iprod_s2);
		dext      = TOT_W'(dprod_s2);
		ilim_ext  = TOT_W'(ilim_q);
		dlim_ext  = TOT_W'(dlim_q);
		olim_ext  = TOT_W'(olim_q);
		iterm     = (iext > ilim_ext) ? ilim_ext : iext;
		dterm     = (dext > dlim_ext) ? dlim_ext : dext;
		total     = pext + iterm + dterm;
		total_hi  = (total > olim_ext) ? olim_ext : total;
		total_lim = (total_hi < TOT_W'(DRIVE_MIN)) ? TOT_W'(DRIVE_MIN) : total_hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			drive_q <= total_lim[DRIVE_W-1:0];
		end
	end

	`PWI_ASSERT_SAME(a_wr_pos_range, clk, arst_n, 1'b1, wr_pos_q <= WIN_IDX_W'(WINDOW_LEN - 1))
	`PWI_ASSERT_NEXT(a_prev_err_tracks, clk, arst_n, accept, prev_err_q == $past(sample.error_sample))
	`PWI_ASSERT_SAME(a_result_from_s2, clk, arst_n, $rose(out_v_q), $past(v_s2))
	`PWI_ASSERT_SAME(a_stall_only_full, clk, arst_n, !sample.ready, v_s1 && v_s2 && out_v_q)

endmodule
